@@ rtl/mi2_pkg.sv @@
// Shared types, constants and modular helper functions for the 2x2 key inverse block.
// No dependencies; used by every other file of the block.
`default_nettype none

package mi2_pkg;

  localparam int MODULUS = 26;
  localparam int ENT_W   = 8;                    // raw input entry width
  localparam int OUT_W   = 5;                    // result field width
  localparam int RES_W   = $clog2(MODULUS);      // width of one residue
  localparam int PROD_W  = 2 * RES_W;            // product of two residues
  localparam int EXT_W   = RES_W + OUT_W;

  // reciprocal factors: floor(2^W / M), quotient estimate is low by at most one
  localparam int K_ENT  = (1 << ENT_W) / MODULUS;
  localparam int K_PROD = (1 << PROD_W) / MODULUS;

  localparam logic [RES_W:0]   MOD_R1 = (RES_W + 1)'(MODULUS);
  localparam logic [RES_W-1:0] RES_ONE = RES_W'(1);
  localparam logic [RES_W-1:0] RES_M1  = RES_W'(MODULUS - 1);

  typedef logic [RES_W-1:0] res_t;

  typedef struct packed {
    logic [ENT_W-1:0] entry_tl;
    logic [ENT_W-1:0] entry_tr;
    logic [ENT_W-1:0] entry_bl;
    logic [ENT_W-1:0] entry_br;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] inv_tl;
    logic [OUT_W-1:0] inv_tr;
    logic [OUT_W-1:0] inv_bl;
    logic [OUT_W-1:0] inv_br;
    logic [OUT_W-1:0] det_residue;
    logic             invertible;
  } out_item_t;

  typedef enum logic [1:0] {
    MSEL_AD = 2'd0,
    MSEL_BC = 2'd1,
    MSEL_SC = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic       red_ad;
    logic       red_bc;
    logic       det_en;
    logic       search_en;
    logic       red_scale;
    logic [1:0] k;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic search_hit;
    logic search_last;
  } stat_t;

  // raw 8-bit entry mod M: reciprocal estimate plus one correction
  function automatic res_t red_ent(input logic [ENT_W-1:0] v);
    logic [2*ENT_W-1:0] t;
    logic [ENT_W-1:0]   q;
    logic [2*ENT_W:0]   qm;
    logic [ENT_W:0]     r;
    t  = v * ENT_W'(K_ENT);
    q  = t[2*ENT_W-1:ENT_W];
    qm = (2*ENT_W + 1)'(q) * (2*ENT_W + 1)'(MODULUS);
    r  = {1'b0, v} - qm[ENT_W:0];
    if (r >= (ENT_W + 1)'(MODULUS)) begin
      r = r - (ENT_W + 1)'(MODULUS);
    end
    return r[RES_W-1:0];
  endfunction

  // product of two residues mod M, same scheme
  function automatic res_t red_prod(input logic [PROD_W-1:0] p);
    logic [2*PROD_W-1:0] t;
    logic [PROD_W-1:0]   q;
    logic [2*PROD_W:0]   qm;
    logic [PROD_W:0]     r;
    t  = p * PROD_W'(K_PROD);
    q  = t[2*PROD_W-1:PROD_W];
    qm = (2*PROD_W + 1)'(q) * (2*PROD_W + 1)'(MODULUS);
    r  = {1'b0, p} - qm[PROD_W:0];
    if (r >= (PROD_W + 1)'(MODULUS)) begin
      r = r - (PROD_W + 1)'(MODULUS);
    end
    return r[RES_W-1:0];
  endfunction

  // (x + y) mod M for residues
  function automatic res_t add_mod(input res_t x, input res_t y);
    logic [RES_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= MOD_R1) begin
      s = s - MOD_R1;
    end
    return s[RES_W-1:0];
  endfunction

  // (x - y) mod M for residues
  function automatic res_t sub_mod(input res_t x, input res_t y);
    logic [RES_W:0] s;
    s = {1'b0, x} + MOD_R1 - {1'b0, y};
    if (s >= MOD_R1) begin
      s = s - MOD_R1;
    end
    return s[RES_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input res_t r);
    logic [EXT_W-1:0] e;
    e = EXT_W'(r);
    return e[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/mi2_dp.sv @@
// Datapath: entry reduction, shared multiply/reduce unit, inverse search, result register.
// Depends on mi2_pkg; driven by mi2_ctrl through mi2_pkg::cmd_t.
`default_nettype none

module mi2_dp (
  input  wire logic              clk,
  input  wire mi2_pkg::cmd_t     cmd,
  input  wire mi2_pkg::in_item_t in_data,
  output mi2_pkg::stat_t         stat,
  output mi2_pkg::out_item_t     out_data
);

  mi2_pkg::res_t a_r, b_r, c_r, d_r;
  mi2_pkg::res_t ad_r, bc_r, det_r, acc_r, x_r, inv_r;
  mi2_pkg::res_t res_r [4];
  logic          ok_r;
  logic [mi2_pkg::PROD_W-1:0] p_r;
  mi2_pkg::out_item_t out_r;

  mi2_pkg::res_t mul_x, mul_y, adj, red_val, det_nxt;

  // adjugate [d, -b; -c, a]
  always_comb begin
    case (cmd.k)
      2'd0:    adj = d_r;
      2'd1:    adj = mi2_pkg::sub_mod('0, b_r);
      2'd2:    adj = mi2_pkg::sub_mod('0, c_r);
      default: adj = a_r;
    endcase
  end

  always_comb begin
    case (cmd.mul_sel)
      mi2_pkg::MSEL_AD: begin
        mul_x = a_r;
        mul_y = d_r;
      end
      mi2_pkg::MSEL_BC: begin
        mul_x = b_r;
        mul_y = c_r;
      end
      default: begin
        mul_x = adj;
        mul_y = inv_r;
      end
    endcase
  end

  assign red_val = mi2_pkg::red_prod(p_r);
  assign det_nxt = mi2_pkg::sub_mod(ad_r, bc_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= mi2_pkg::red_ent(in_data.entry_tl);
      b_r <= mi2_pkg::red_ent(in_data.entry_tr);
      c_r <= mi2_pkg::red_ent(in_data.entry_bl);
      d_r <= mi2_pkg::red_ent(in_data.entry_br);
    end
    if (cmd.mul_en) begin
      p_r <= mi2_pkg::PROD_W'(mul_x) * mi2_pkg::PROD_W'(mul_y);
    end
    if (cmd.red_ad) begin
      ad_r <= red_val;
    end
    if (cmd.red_bc) begin
      bc_r <= red_val;
    end
    if (cmd.red_scale) begin
      res_r[cmd.k] <= red_val;
    end
    if (cmd.det_en) begin
      det_r <= det_nxt;
      acc_r <= det_nxt;
      x_r   <= mi2_pkg::RES_ONE;
      inv_r <= '0;
      ok_r  <= 1'b0;
    end else if (cmd.search_en) begin
      // acc_r tracks det * x_r mod M
      if (acc_r == mi2_pkg::RES_ONE) begin
        inv_r <= x_r;
        ok_r  <= 1'b1;
      end else begin
        x_r   <= x_r + mi2_pkg::RES_ONE;
        acc_r <= mi2_pkg::add_mod(acc_r, det_r);
      end
    end
    if (cmd.out_load) begin
      out_r.inv_tl      <= mi2_pkg::to_out(res_r[0]);
      out_r.inv_tr      <= mi2_pkg::to_out(res_r[1]);
      out_r.inv_bl      <= mi2_pkg::to_out(res_r[2]);
      out_r.inv_br      <= mi2_pkg::to_out(res_r[3]);
      out_r.det_residue <= mi2_pkg::to_out(det_r);
      out_r.invertible  <= ok_r;
    end
  end

  assign stat.search_hit  = (acc_r == mi2_pkg::RES_ONE);
  assign stat.search_last = (x_r == mi2_pkg::RES_M1);
  assign out_data         = out_r;

endmodule

`default_nettype wire

@@ rtl/mi2_ctrl.sv @@
// Controller: sequences load, multiply/reduce steps, inverse search and output transfer.
// Depends on mi2_pkg; drives mi2_dp through mi2_pkg::cmd_t.
`default_nettype none

module mi2_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire mi2_pkg::stat_t stat,
  output mi2_pkg::cmd_t       cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_MUL_AD = 10'b00_0000_0010,
    ST_RED_AD = 10'b00_0000_0100,
    ST_MUL_BC = 10'b00_0000_1000,
    ST_RED_BC = 10'b00_0001_0000,
    ST_DET    = 10'b00_0010_0000,
    ST_SEARCH = 10'b00_0100_0000,
    ST_SC_MUL = 10'b00_1000_0000,
    ST_SC_RED = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mul_sel   = mi2_pkg::MSEL_AD;
    cmd.k         = k_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL_AD;
        end
      end
      ST_MUL_AD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mi2_pkg::MSEL_AD;
        state_nxt   = ST_RED_AD;
      end
      ST_RED_AD: begin
        cmd.red_ad = 1'b1;
        state_nxt  = ST_MUL_BC;
      end
      ST_MUL_BC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mi2_pkg::MSEL_BC;
        state_nxt   = ST_RED_BC;
      end
      ST_RED_BC: begin
        cmd.red_bc = 1'b1;
        state_nxt  = ST_DET;
      end
      ST_DET: begin
        cmd.det_en = 1'b1;
        k_nxt      = '0;
        state_nxt  = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search_en = 1'b1;
        if (stat.search_hit || stat.search_last) begin
          state_nxt = ST_SC_MUL;
        end
      end
      ST_SC_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mi2_pkg::MSEL_SC;
        state_nxt   = ST_SC_RED;
      end
      ST_SC_RED: begin
        cmd.red_scale = 1'b1;
        if (k_r == 2'd3) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_SC_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/modular_inverse_2x2_matrix_top.sv @@
// Top level of the 2x2 key inverse mod MODULUS: controller plus datapath.
// Depends on mi2_pkg, mi2_ctrl and mi2_dp.
//
// Usage:
//  - Input channel in_valid / in_stall / in_data carries one 2x2 matrix of raw
//    8-bit entries; a transfer happens when in_valid is high and in_stall low.
//  - Output channel out_valid / out_stall / out_data carries the inverse mod
//    MODULUS, the determinant residue and the invertible flag, one result per
//    input. A zero inverse with invertible low means a singular matrix.
//  - One matrix is worked on at a time. in_stall is low only while idle.
//  - After an input transfer the matrix goes in order through passes of the shared
//    multiply/reduce unit for ad and bc, one determinant step, the inverse search
//    (candidates 1 to MODULUS-1, one candidate per cycle against the running det*x
//    residue), four passes for the adjugate scalings and the output register load.
//    Each of the six passes is a multiply state followed by a reduce state.
//  - The next matrix is taken the cycle after a result is loaded, even if the
//    receiver still stalls it; a finished result then waits in the done state
//    until the output register frees up.
//  - While out_valid and out_stall are both high the output payload holds.
//  - rst_n (synchronous, active low) returns the controller to idle and drops
//    out_valid; any matrix in flight is discarded.
`default_nettype none

module modular_inverse_2x2_matrix_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mi2_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mi2_pkg::out_item_t      out_data
);

  mi2_pkg::cmd_t  cmd;   // controller -> datapath
  mi2_pkg::stat_t stat;  // datapath -> controller (search status)

  mi2_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mi2_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/mi2_chk.sv @@
// Port-level checker for the 2x2 key inverse top level, attached by bind.
// Depends on mi2_pkg and modular_inverse_2x2_matrix_top.
`default_nettype none

module mi2_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire mi2_pkg::out_item_t out_data
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one matrix at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while busy");

  // singular matrix gives a zero inverse
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.invertible |->
      out_data.inv_tl == '0 && out_data.inv_tr == '0 &&
      out_data.inv_bl == '0 && out_data.inv_br == '0)
    else $error("singular matrix with nonzero inverse");

  // every determinant residue is below the modulus, and an invertible one is nonzero
  a_det_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mi2_pkg::MODULUS > 32) ||
      ((32'(out_data.det_residue) < mi2_pkg::MODULUS) &&
       (!out_data.invertible || out_data.det_residue != '0)))
    else $error("determinant residue out of range");

endmodule

bind modular_inverse_2x2_matrix_top mi2_chk u_chk (.*);

`default_nettype wire

@@ dv/mi2_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the 2x2 key inverse block. It watches both channels, predicts each result
// from the accepted matrix and checks it field by field. Depends on mi2_pkg for types and modulus.
module mi2_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mi2_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  mi2_pkg::out_item_t out_data,
  output int                 n_errors,
  output int                 n_pending,
  output int                 n_results,
  output int                 n_invertible
);
  import mi2_pkg::*;

  localparam int MAX_REPORTS = 50;

  out_item_t inverse_q[$];
  in_item_t  matrix_q[$];

  // Reduce entries, form ad - bc, search for the determinant's inverse, then scale the adjugate.
  // A singular determinant leaves det_inv at zero, so the inverse comes out all zero.
  function automatic out_item_t invert_key(input in_item_t m);
    int unsigned a, b, c, d, det, det_inv, x;
    out_item_t   r;
    a = m.entry_tl % MODULUS;
    b = m.entry_tr % MODULUS;
    c = m.entry_bl % MODULUS;
    d = m.entry_br % MODULUS;
    det = (a * d + MODULUS * MODULUS - b * c) % MODULUS;
    det_inv = 0;
    for (x = 1; x < MODULUS; x++) begin
      if ((det * x) % MODULUS == 1) begin
        det_inv = x;
      end
    end
    r.inv_tl      = OUT_W'((d * det_inv) % MODULUS);
    r.inv_tr      = OUT_W'((((MODULUS - b) % MODULUS) * det_inv) % MODULUS);
    r.inv_bl      = OUT_W'((((MODULUS - c) % MODULUS) * det_inv) % MODULUS);
    r.inv_br      = OUT_W'((a * det_inv) % MODULUS);
    r.det_residue = OUT_W'(det);
    r.invertible  = (det_inv != 0);
    return r;
  endfunction

  task automatic check_field(input string fname, input int want, input int got,
                             input in_item_t src);
    if (want != got) begin
      if (n_errors < MAX_REPORTS) begin
        $display("%0t: %s mismatch, matrix [%0d %0d; %0d %0d]: expected %0d, actual %0d",
                 $time, fname, src.entry_tl, src.entry_tr, src.entry_bl, src.entry_br,
                 want, got);
      end
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    in_item_t  src;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: result with nothing outstanding: expected none, actual %h",
                   $time, out_data);
          n_errors++;
        end else begin
          want = inverse_q.pop_front();
          src  = matrix_q.pop_front();
          check_field("inv_tl", want.inv_tl, out_data.inv_tl, src);
          check_field("inv_tr", want.inv_tr, out_data.inv_tr, src);
          check_field("inv_bl", want.inv_bl, out_data.inv_bl, src);
          check_field("inv_br", want.inv_br, out_data.inv_br, src);
          check_field("det_residue", want.det_residue, out_data.det_residue, src);
          check_field("invertible", want.invertible, out_data.invertible, src);
          n_results    <= n_results + 1;
          n_invertible <= n_invertible + int'(want.invertible);
        end
      end
      if (in_valid && !in_stall) begin
        inverse_q.push_back(invert_key(in_data));
        matrix_q.push_back(in_data);
      end
    end
    n_pending <= inverse_q.size();
  end

endmodule

@@ dv/tb_modular_inverse_2x2_matrix_top.sv @@
`timescale 1ns / 1ps
// Top of the 2x2 key inverse testbench: clock, reset, matrix stimulus, result-side stalls
// and the verdict. Depends on mi2_pkg, mi2_checker and modular_inverse_2x2_matrix_top.
module tb_modular_inverse_2x2_matrix_top;
  import mi2_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_AT      = 250;   // receiver starts its long hold-off here
  localparam int PAUSE_AT     = 500;   // sender drains the block here
  localparam int TAIL_AT      = 900;   // from here on neither side idles
  localparam int HOLD_CYCLES  = 300;
  // Leave margin after the last result.
  localparam int DRAIN_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int n_errors, n_pending, n_results, n_invertible;
  int n_sent;

  // Flags handed from the matrix sender to the result-side process.
  logic hold_req   = 1'b0;
  logic tail_phase = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  modular_inverse_2x2_matrix_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  mi2_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .n_errors    (n_errors),
    .n_pending   (n_pending),
    .n_results   (n_results),
    .n_invertible(n_invertible)
  );

  // Offer one matrix and hold it until the transfer happens.
  task automatic send_entries(input logic [ENT_W-1:0] tl, input logic [ENT_W-1:0] tr,
                              input logic [ENT_W-1:0] bl, input logic [ENT_W-1:0] br);
    in_item_t m;
    m.entry_tl = tl;
    m.entry_tr = tr;
    m.entry_bl = bl;
    m.entry_br = br;
    in_valid <= 1'b1;
    in_data  <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // Drop valid and wait until every outstanding inverse has come back.
  // The first edge lets the checker count the transfer that just happened.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // Full byte range, reduced residues, or values around the modulus and its multiples.
  function automatic logic [ENT_W-1:0] pick_entry(input int kind);
    int sel;
    sel = $urandom_range(0, 5);
    if (kind == 0) begin
      return ENT_W'($urandom_range(0, 255));
    end else if (kind == 1) begin
      return ENT_W'($urandom_range(0, MODULUS - 1));
    end
    case (sel)
      0: return '0;
      1: return ENT_W'(MODULUS - 1);
      2: return ENT_W'(MODULUS);
      3: return '1;
      4: return ENT_W'(MODULUS / 2);
      default: return ENT_W'($urandom_range(0, 9) * MODULUS);
    endcase
  endfunction

  // Matrix sender: directed corners first, then random matrices with bursty gaps.
  initial begin
    int kind, tx_mode;
    tx_mode  = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_entries(0, 0, 0, 0);            // zero determinant
    send_entries(255, 255, 255, 255);    // top of range, still singular
    send_entries(1, 0, 0, 1);            // identity
    send_entries(3, 3, 2, 5);            // textbook cipher key
    send_entries(26, 52, 78, 104);       // every entry a multiple of the modulus
    send_entries(0, 1, 1, 0);            // determinant wraps negative to 25
    send_entries(25, 0, 0, 25);          // largest residues on the diagonal
    send_entries(255, 0, 0, 255);
    send_entries(0, 255, 255, 0);        // raw entries reduce before the product
    send_entries(2, 0, 0, 1);            // even determinant, shares factor 2
    send_entries(13, 0, 0, 1);           // shares factor 13
    send_entries(4, 2, 2, 3);            // nonzero but even determinant
    send_entries(27, 1, 0, 27);          // wraps to the unit upper triangle
    send_entries(170, 85, 85, 170);      // alternating bit patterns
    send_entries(85, 170, 170, 85);
    send_entries(128, 64, 32, 16);
    send_entries(25, 25, 25, 24);
    send_entries(7, 0, 0, 11);
    send_entries(5, 17, 8, 3);
    send_entries(1, 25, 25, 1);          // determinant zero via wrap
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        tx_mode = $urandom_range(0, 2);
      end
      if (i == HOLD_AT) begin
        hold_req = 1'b1;
      end
      if (i == PAUSE_AT) begin
        wait_drained();
      end
      if (i == TAIL_AT) begin
        tail_phase = 1'b1;
      end
      // mode 0 streams back to back, mode 1 idles now and then, mode 2 idles often
      if (!tail_phase && tx_mode != 0 &&
          $urandom_range(0, (tx_mode == 1) ? 7 : 1) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      kind = $urandom_range(0, 9);
      kind = (kind < 5) ? 0 : (kind < 8) ? 1 : 2;
      send_entries(pick_entry(kind), pick_entry(kind), pick_entry(kind), pick_entry(kind));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d matrices transferred, %0d inverses checked (%0d invertible, %0d singular).",
             n_sent, n_results, n_invertible, n_results - n_invertible);
    $display("Covered raw entries 0..255, a %0d-cycle result hold-off with input backpressure, and a full drain.",
             HOLD_CYCLES);
    if (n_errors == 0 && n_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random stall bursts, long free stretches, one long hold-off so the block
  // fills and pushes back on its input, and no stalls at all in the tail of the run.
  initial begin
    int pick;
    out_stall <= 1'b0;
    forever begin
      pick = $urandom_range(0, 9);
      if (!rst_n || tail_phase) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (pick < 3) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else if (pick == 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Watchdog: reports a timeout and fails the run if the stimulus has not finished by then;
  // the slowest legal run is set by search, gaps, stalls and the hold-off per matrix.
  initial begin
    #4_800_000;
    $display("%0t: timeout with %0d results outstanding", $time, n_pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mi2_pkg.sv
rtl/mi2_dp.sv
rtl/mi2_ctrl.sv
rtl/modular_inverse_2x2_matrix_top.sv
rtl/mi2_chk.sv
dv/mi2_checker.sv
dv/tb_modular_inverse_2x2_matrix_top.sv
